>>> hw/rtl/bdd_pkg.sv
package bdd_pkg;

  // Two-bit difference size code per dataset
  typedef enum logic [1:0] {
    SZ_NONE = 2'd0,
    SZ_BYTE = 2'd1,
    SZ_HALF = 2'd2,
    SZ_WORD = 2'd3
  } size_e;

  localparam int unsigned NUM_DS     = 4;
  localparam logic [7:0]  SIZE_MASK  = 8'h03;
  localparam logic        ACT_START  = 1'b0;
  localparam logic        ACT_BUNDLE = 1'b1;

  // Classified word handed from the front end to the back end
  typedef struct packed {
    logic                           is_start;
    logic signed [23:0]             first;
    logic [NUM_DS-1:0][1:0]         size;
    logic [NUM_DS-1:0][31:0]        data;
    logic [1:0]                     first_ds;
    logic [NUM_DS-1:0]              final_ds;
  } cmd_t;

  // Result word
  typedef struct packed {
    logic signed [31:0] sample;
    logic               last;
  } res_t;

endpackage

>>> hw/rtl/bdd_fifo.sv
module bdd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/bdd_front.sv
module bdd_front import bdd_pkg::*; (
  input  logic               push_i,
  input  logic               action_i,
  input  logic signed [23:0] first_sample_i,
  input  logic [7:0]         bundle_code_i,
  input  logic [31:0]        dataset0_i,
  input  logic [31:0]        dataset1_i,
  input  logic [31:0]        dataset2_i,
  input  logic [31:0]        dataset3_i,
  input  logic               cmd_full_i,
  output logic               cmd_push_o,
  output cmd_t               cmd_o
);

  logic [NUM_DS-1:0] nz;

  // Split the code byte; dataset 0 sits in the top bits
  always_comb begin
    cmd_o          = '0;
    cmd_o.is_start = (action_i == ACT_START);
    cmd_o.first    = first_sample_i;
    cmd_o.data[0]  = dataset0_i;
    cmd_o.data[1]  = dataset1_i;
    cmd_o.data[2]  = dataset2_i;
    cmd_o.data[3]  = dataset3_i;
    for (int i = 0; i < NUM_DS; i++) begin
      cmd_o.size[i] = 2'((bundle_code_i >> (6 - 2 * i)) & SIZE_MASK);
      nz[i]         = (cmd_o.size[i] != SZ_NONE);
    end
    // first dataset that carries data
    cmd_o.first_ds = 2'd0;
    for (int i = NUM_DS - 1; i >= 0; i--) begin
      if (nz[i]) cmd_o.first_ds = 2'(i);
    end
    // dataset i is the last one with data when nothing follows it
    for (int i = 0; i < NUM_DS; i++) begin
      cmd_o.final_ds[i] = ~|(nz >> (i + 1));
    end
  end

  // Bundles with no data produce nothing and are dropped here
  assign cmd_push_o = push_i && !cmd_full_i && (cmd_o.is_start || (|nz));

endmodule

>>> hw/rtl/bdd_back.sv
module bdd_back import bdd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_empty_i,
  output logic cmd_pop_o,
  input  logic res_full_i,
  output logic res_push_o,
  output res_t res_o
);

  logic [31:0] run_q, run_d;
  logic [1:0]  ds_q, ds_d, j_q, j_d;
  logic        fresh_q, fresh_d;

  logic [1:0]  eff_ds, eff_j, nxt_ds;
  size_e       cur_size;
  logic [31:0] cur_data, diff;
  logic [7:0]  dbyte;
  logic [15:0] dhalf;
  logic        elem_last, item_last, go;

  assign go = !cmd_empty_i && !res_full_i;

  // Current difference selection
  always_comb begin
    eff_ds    = fresh_q ? cmd_i.first_ds : ds_q;
    eff_j     = fresh_q ? 2'd0 : j_q;
    cur_size  = size_e'(cmd_i.size[eff_ds]);
    cur_data  = cmd_i.data[eff_ds];
    dbyte     = cur_data[{eff_j, 3'b000} +: 8];
    dhalf     = cur_data[{eff_j[0], 4'b0000} +: 16];
    diff      = '0;
    elem_last = 1'b1;
    unique case (cur_size)
      SZ_BYTE: begin
        diff      = {{24{dbyte[7]}}, dbyte};
        elem_last = (eff_j == 2'd3);
      end
      SZ_HALF: begin
        diff      = {{16{dhalf[15]}}, dhalf};
        elem_last = eff_j[0];
      end
      SZ_WORD: begin
        diff      = cur_data;
        elem_last = 1'b1;
      end
      default: begin
        diff      = '0;
        elem_last = 1'b1;
      end
    endcase

    // next dataset with data after the current one
    nxt_ds = eff_ds;
    for (int k = NUM_DS - 1; k >= 0; k--) begin
      if ((k > int'(eff_ds)) && (cmd_i.size[k] != SZ_NONE)) nxt_ds = 2'(k);
    end
  end

  // Sum and sequencing
  always_comb begin
    run_d   = run_q;
    ds_d    = ds_q;
    j_d     = j_q;
    fresh_d = fresh_q;
    if (cmd_i.is_start) begin
      item_last = 1'b1;
      res_o.sample = {{8{cmd_i.first[23]}}, cmd_i.first};
    end else begin
      item_last = elem_last && cmd_i.final_ds[eff_ds];
      res_o.sample = run_q + diff;
    end
    res_o.last = item_last;
    if (go) begin
      run_d = res_o.sample;
      if (item_last) begin
        fresh_d = 1'b1;
      end else begin
        fresh_d = 1'b0;
        ds_d    = elem_last ? nxt_ds : eff_ds;
        j_d     = elem_last ? 2'd0 : eff_j + 2'd1;
      end
    end
  end

  assign res_push_o = go;
  assign cmd_pop_o  = go && item_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= '0;
      ds_q    <= '0;
      j_q     <= '0;
      fresh_q <= 1'b1;
    end else begin
      run_q   <= run_d;
      ds_q    <= ds_d;
      j_q     <= j_d;
      fresh_q <= fresh_d;
    end
  end

endmodule

>>> hw/rtl/bundle_difference_decoder_top.sv
// First-difference decoder for seismic sample packets. A start word loads the
// running sample with its signed 24-bit first value and returns it as one
// result word marked last. A bundle word carries a code byte and four
// datasets, each decoded as four byte, two 16-bit or one 32-bit signed
// difference (or nothing); every difference is added to the running sample
// with 32-bit wrap and the new value is returned, the final one marked last.
// A bundle whose codes are all zero returns nothing. The front end takes one
// input word per cycle while its command queue has room; the back end emits
// one result word per cycle while a command waits and the result queue has
// room. A word yields 1 to 16 results, and an empty bundle is dropped at the
// front only. The adder on the running sample in the back end sets the back
// end's pace. Results wait in an output queue, so input keeps flowing while
// pop is held low until both queues fill.
module bundle_difference_decoder_top import bdd_pkg::*; #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic signed [23:0] first_sample_i,
  input  logic [7:0]         bundle_code_i,
  input  logic [31:0]        dataset0_i,
  input  logic [31:0]        dataset1_i,
  input  logic [31:0]        dataset2_i,
  input  logic [31:0]        dataset3_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] sample_o,
  output logic               last_o
);

  cmd_t cmd_in, cmd_head;
  logic cmd_push, cmd_pop, cmd_full, cmd_empty;
  res_t res_in, res_head;
  logic res_push, res_full;

  // Front end: classify incoming words
  bdd_front u_front (
    .push_i         (push),
    .action_i       (action_i),
    .first_sample_i (first_sample_i),
    .bundle_code_i  (bundle_code_i),
    .dataset0_i     (dataset0_i),
    .dataset1_i     (dataset1_i),
    .dataset2_i     (dataset2_i),
    .dataset3_i     (dataset3_i),
    .cmd_full_i     (cmd_full),
    .cmd_push_o     (cmd_push),
    .cmd_o          (cmd_in)
  );

  assign full = cmd_full;

  // Command queue between front and back
  bdd_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty)
  );

  // Back end: accumulate differences
  bdd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_in)
  );

  // Result queue
  bdd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty)
  );

  assign sample_o = res_head.sample;
  assign last_o   = res_head.last;

endmodule
